[rtl/core/msbp_pkg.sv]
// Shared types, operation codes and default sizes for the MSB-first bit packer.
// Used by msbp_front, msbp_back and the top level in rtl/core; has no dependencies.
package msbp_pkg;

    localparam int MAX_FIELD_BITS = 32;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [2:0] OP_BITS  = 3'd0;
    localparam logic [2:0] OP_U8    = 3'd1;
    localparam logic [2:0] OP_U16   = 3'd2;
    localparam logic [2:0] OP_U32   = 3'd3;
    localparam logic [2:0] OP_FLUSH = 3'd4;

    typedef enum logic [1:0] {
        KIND_BITS    = 2'd0,
        KIND_ALIGNED = 2'd1,
        KIND_FLUSH   = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [2:0] bytes;
    } ctl_t;

endpackage

[rtl/core/msbp_queue.sv]
// Small register FIFO that decouples the request decoder from the byte emitter.
// Generic width and depth; no package dependencies.
module msbp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign valid   = (count_reg != '0);
    assign do_push = push && !full;
    assign do_pop  = pop && valid;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[rtl/core/msbp_front.sv]
// Request decoder: classifies each operation and left-aligns bit fields.
// Depends on msbp_pkg.
module msbp_front #(
    parameter int MFB = msbp_pkg::MAX_FIELD_BITS,
    parameter int CW  = $clog2(MFB + 1)
) (
    input  logic [2:0]     op,
    input  logic [31:0]    value,
    input  logic [5:0]     nbits,
    output logic           cmd_valid,
    output msbp_pkg::ctl_t cmd_ctl,
    output logic [MFB-1:0] cmd_field,
    output logic [CW-1:0]  cmd_cnt,
    output logic [31:0]    cmd_data
);
    import msbp_pkg::*;

    logic [MFB+31:0] value_ext;
    logic [MFB-1:0]  value_fit;
    logic [CW-1:0]   nbits_sat;
    logic [CW-1:0]   align_shift;

    assign value_ext   = {{MFB{1'b0}}, value};
    assign value_fit   = value_ext[MFB-1:0];
    assign nbits_sat   = ({1'b0, nbits} > 7'(MFB)) ? CW'(MFB) : CW'(nbits);
    assign align_shift = CW'(MFB) - nbits_sat;

    always_comb
    begin
        cmd_valid       = 1'b0;
        cmd_ctl.kind    = KIND_BITS;
        cmd_ctl.bytes   = 3'd0;
        cmd_field       = '0;
        cmd_cnt         = '0;
        cmd_data        = value;
        unique case (op)
            OP_BITS:
            begin
                cmd_valid = (nbits_sat != '0);
                cmd_field = value_fit << align_shift;
                cmd_cnt   = nbits_sat;
            end
            OP_U8:
            begin
                cmd_valid     = 1'b1;
                cmd_ctl.kind  = KIND_ALIGNED;
                cmd_ctl.bytes = 3'd1;
            end
            OP_U16:
            begin
                cmd_valid     = 1'b1;
                cmd_ctl.kind  = KIND_ALIGNED;
                cmd_ctl.bytes = 3'd2;
            end
            OP_U32:
            begin
                cmd_valid     = 1'b1;
                cmd_ctl.kind  = KIND_ALIGNED;
                cmd_ctl.bytes = 3'd4;
            end
            OP_FLUSH:
            begin
                cmd_valid    = 1'b1;
                cmd_ctl.kind = KIND_FLUSH;
            end
            default:
            begin
                cmd_valid = 1'b0;
            end
        endcase
    end

endmodule

[rtl/core/msbp_back.sv]
// Byte emitter: holds the partial byte and produces at most one output byte per step.
// Depends on msbp_pkg; fed from msbp_queue.
module msbp_back #(
    parameter int MFB = msbp_pkg::MAX_FIELD_BITS,
    parameter int CW  = $clog2(MFB + 1)
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    output logic           q_pop,
    input  msbp_pkg::ctl_t q_ctl,
    input  logic [MFB-1:0] q_field,
    input  logic [CW-1:0]  q_cnt,
    input  logic [31:0]    q_data,
    output logic           empty,
    input  logic           pop,
    output logic [7:0]     out_byte,
    output logic           last
);
    import msbp_pkg::*;

    logic           busy_reg;
    logic           busy_next;
    ctl_t           ctl_reg;
    logic [MFB-1:0] field_reg;
    logic [MFB-1:0] field_next;
    logic [CW-1:0]  rem_reg;
    logic [CW-1:0]  rem_next;
    logic [31:0]    data_reg;
    logic [31:0]    data_next;
    logic [2:0]     bytes_reg;
    logic [2:0]     bytes_next;
    logic [7:0]     partial_reg;
    logic [7:0]     partial_next;
    logic [2:0]     fill_reg;
    logic [2:0]     fill_next;
    logic           out_valid_reg;
    logic [7:0]     out_byte_reg;
    logic           last_reg;

    logic [3:0]     free;
    logic [3:0]     take_cnt;
    logic [3:0]     fill_sum;
    logic [7:0]     top8;
    logic [7:0]     take_bits;
    logic [7:0]     merged;
    logic [CW-1:0]  rem_after;
    logic           step_emit;
    logic           step_done;
    logic [7:0]     step_byte;
    logic           step_last;
    logic           slot_free;
    logic           step_fire;
    logic           load;

    assign free      = 4'd8 - {1'b0, fill_reg};
    assign take_cnt  = (rem_reg >= CW'(free)) ? free : 4'(rem_reg);
    assign fill_sum  = {1'b0, fill_reg} + take_cnt;
    assign top8      = field_reg[MFB-1 -: 8];
    assign take_bits = top8 >> (4'd8 - take_cnt);
    assign merged    = partial_reg | 8'(take_bits << (free - take_cnt));
    assign rem_after = rem_reg - CW'(take_cnt);

    always_comb
    begin
        step_emit    = 1'b0;
        step_done    = 1'b0;
        step_byte    = partial_reg;
        step_last    = 1'b0;
        partial_next = partial_reg;
        fill_next    = fill_reg;
        field_next   = field_reg;
        rem_next     = rem_reg;
        data_next    = data_reg;
        bytes_next   = bytes_reg;
        unique case (ctl_reg.kind)
            KIND_BITS:
            begin
                field_next = field_reg << take_cnt;
                rem_next   = rem_after;
                step_done  = (rem_after == '0);
                if (fill_sum == 4'd8)
                begin
                    step_emit    = 1'b1;
                    step_byte    = merged;
                    step_last    = (rem_after < CW'(8));
                    partial_next = 8'd0;
                    fill_next    = 3'd0;
                end
                else
                begin
                    partial_next = merged;
                    fill_next    = fill_sum[2:0];
                end
            end
            KIND_ALIGNED:
            begin
                step_emit = 1'b1;
                if (fill_reg != 3'd0)
                begin
                    step_byte    = partial_reg;
                    partial_next = 8'd0;
                    fill_next    = 3'd0;
                end
                else
                begin
                    step_byte  = data_reg[7:0];
                    step_last  = (bytes_reg == 3'd1);
                    step_done  = (bytes_reg == 3'd1);
                    data_next  = data_reg >> 8;
                    bytes_next = bytes_reg - 3'd1;
                end
            end
            KIND_FLUSH:
            begin
                step_done = 1'b1;
                if (fill_reg != 3'd0)
                begin
                    step_emit    = 1'b1;
                    step_byte    = partial_reg;
                    step_last    = 1'b1;
                    partial_next = 8'd0;
                    fill_next    = 3'd0;
                end
            end
            default:
            begin
                step_done = 1'b1;
            end
        endcase
    end

    assign slot_free = !out_valid_reg || pop;
    assign step_fire = busy_reg && (!step_emit || slot_free);
    assign load      = q_valid && (!busy_reg || (step_fire && step_done));
    assign q_pop     = load;
    assign busy_next = load ? 1'b1 : ((step_fire && step_done) ? 1'b0 : busy_reg);

    assign empty    = !out_valid_reg;
    assign out_byte = out_byte_reg;
    assign last     = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            partial_reg   <= 8'd0;
            fill_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (step_fire)
            begin
                partial_reg <= partial_next;
                fill_reg    <= fill_next;
            end
            if (step_fire && step_emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ctl_reg   <= q_ctl;
            field_reg <= q_field;
            rem_reg   <= q_cnt;
            data_reg  <= q_data;
            bytes_reg <= q_ctl.bytes;
        end
        else if (step_fire)
        begin
            field_reg <= field_next;
            rem_reg   <= rem_next;
            data_reg  <= data_next;
            bytes_reg <= bytes_next;
        end
        if (step_fire && step_emit)
        begin
            out_byte_reg <= step_byte;
            last_reg     <= step_last;
        end
    end

endmodule

[rtl/core/msb_first_bit_packer.sv]
// MSB-first bit packer top level: decoder, request queue and byte emitter.
// Requests pass the queue and the emitter's request registers; the emitter then
// produces one byte per cycle while its output is empty or popped. A bit write that
// leaves leftover bits, or a flush with no partial byte, takes a step with no byte.
// Zero-width writes and unused codes never reach the emitter.
// Reset clears the partial byte, the queue and the output valid flag at once.
module msb_first_bit_packer #(
    parameter int MAX_FIELD_BITS = msbp_pkg::MAX_FIELD_BITS,
    parameter int QUEUE_DEPTH    = msbp_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  op,
    input  logic [31:0] value,
    input  logic [5:0]  nbits,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        last
);
    import msbp_pkg::*;

    localparam int CW = $clog2(MAX_FIELD_BITS + 1);
    localparam int CTLW = $bits(ctl_t);
    localparam int EW = CTLW + MAX_FIELD_BITS + CW + 32;

    logic                      f_valid;
    ctl_t                      f_ctl;
    logic [MAX_FIELD_BITS-1:0] f_field;
    logic [CW-1:0]             f_cnt;
    logic [31:0]               f_data;
    logic [EW-1:0]             q_wdata;
    logic [EW-1:0]             q_rdata;
    logic                      q_valid;
    logic                      q_pop;
    ctl_t                      q_ctl;
    logic [MAX_FIELD_BITS-1:0] q_field;
    logic [CW-1:0]             q_cnt;
    logic [31:0]               q_data;

    msbp_front #(
        .MFB (MAX_FIELD_BITS),
        .CW  (CW)
    ) u_front (
        .op        (op),
        .value     (value),
        .nbits     (nbits),
        .cmd_valid (f_valid),
        .cmd_ctl   (f_ctl),
        .cmd_field (f_field),
        .cmd_cnt   (f_cnt),
        .cmd_data  (f_data)
    );

    assign q_wdata = {f_ctl, f_field, f_cnt, f_data};

    msbp_queue #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push && f_valid),
        .full  (full),
        .pop   (q_pop),
        .valid (q_valid),
        .wdata (q_wdata),
        .rdata (q_rdata)
    );

    assign q_ctl   = ctl_t'(q_rdata[EW-1 -: CTLW]);
    assign q_field = q_rdata[MAX_FIELD_BITS+CW+31 -: MAX_FIELD_BITS];
    assign q_cnt   = q_rdata[CW+31 -: CW];
    assign q_data  = q_rdata[31:0];

    msbp_back #(
        .MFB (MAX_FIELD_BITS),
        .CW  (CW)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_ctl    (q_ctl),
        .q_field  (q_field),
        .q_cnt    (q_cnt),
        .q_data   (q_data),
        .empty    (empty),
        .pop      (pop),
        .out_byte (out_byte),
        .last     (last)
    );

endmodule

[tb/tb_top.sv]
// Self-checking testbench for msb_first_bit_packer: drives field requests, predicts the
// packed byte stream in a scoreboard class and checks every popped byte against it.
// Depends on msbp_pkg and the msb_first_bit_packer RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import msbp_pkg::*;

    localparam logic [2:0] OP_RSVD_A = 3'd5;
    localparam logic [2:0] OP_RSVD_B = 3'd6;
    localparam logic [2:0] OP_RSVD_C = 3'd7;
    localparam int RANDOM_REQUESTS   = 250;
    localparam int IDLE_LIMIT        = 3000;
    localparam int DRAIN_CYCLES      = 24;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } packed_byte_t;

    class packer_scoreboard;
        logic [7:0]   partial;
        int unsigned  fill;
        packed_byte_t byte_q[$];
        int           errors;

        function new();
            partial = 8'h00;
            fill    = 0;
            errors  = 0;
        endfunction

        function void append_bit(logic b);
            packed_byte_t item;
            if (b)
                partial[7 - fill] = 1'b1;
            fill++;
            if (fill == 8)
            begin
                item.data = partial;
                item.last = 1'b0;
                byte_q.push_back(item);
                partial = 8'h00;
                fill    = 0;
            end
        endfunction

        function void flush_partial();
            packed_byte_t item;
            if (fill != 0)
            begin
                item.data = partial;
                item.last = 1'b0;
                byte_q.push_back(item);
            end
            partial = 8'h00;
            fill    = 0;
        endfunction

        function void note_request(logic [2:0] code, logic [31:0] data, logic [5:0] width);
            int           before_count;
            int           field_bits;
            int           nbytes;
            logic [63:0]  wide;
            packed_byte_t item;
            before_count = byte_q.size();
            wide         = {32'h0, data};
            nbytes       = 0;
            case (code)
                OP_BITS:
                begin
                    field_bits = (width > MAX_FIELD_BITS) ? MAX_FIELD_BITS : int'(width);
                    for (int i = field_bits - 1; i >= 0; i--)
                        append_bit(wide[i]);
                end
                OP_U8, OP_U16, OP_U32:
                begin
                    flush_partial();
                    nbytes = (code == OP_U8) ? 1 : (code == OP_U16) ? 2 : 4;
                    for (int k = 0; k < nbytes; k++)
                    begin
                        item.data = data[8 * k +: 8];
                        item.last = 1'b0;
                        byte_q.push_back(item);
                    end
                end
                OP_FLUSH:
                    flush_partial();
                default:
                    ;
            endcase
            if (byte_q.size() > before_count)
            begin
                item      = byte_q.pop_back();
                item.last = 1'b1;
                byte_q.push_back(item);
            end
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_byte(logic [7:0] data, logic last);
            packed_byte_t item;
            if (byte_q.size() == 0)
                report($sformatf("unexpected byte %02h last %0b", data, last));
            else
            begin
                item = byte_q.pop_front();
                if (data !== item.data)
                    report($sformatf("out_byte %02h, expected %02h", data, item.data));
                if (last !== item.last)
                    report($sformatf("last %0b on byte %02h, expected %0b",
                                     last, data, item.last));
            end
        endtask

        function int pending();
            return byte_q.size();
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        push     = 1'b0;
    logic [2:0]  op       = OP_BITS;
    logic [31:0] value    = 32'h0;
    logic [5:0]  nbits    = 6'd0;
    logic        pop      = 1'b0;
    logic        full;
    logic        empty;
    logic [7:0]  out_byte;
    logic        last;

    packer_scoreboard sb = new();
    int idle_cycles  = 0;
    int burst_left   = 0;
    int rx_mode      = 0;
    int rx_phase     = 0;
    int rx_stall     = 0;
    int rx_tick      = 0;

    msb_first_bit_packer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .op       (op),
        .value    (value),
        .nbits    (nbits),
        .empty    (empty),
        .pop      (pop),
        .out_byte (out_byte),
        .last     (last)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && push && !full)
            sb.note_request(op, value, nbits);
        if (rst_n && pop && !empty)
            sb.check_byte(out_byte, last);
        if (rst_n && ((push && !full) || (pop && !empty)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // The receiver switches between steady popping, random stalls, a sparse
    // periodic pattern and occasional long stalls.
    always @(negedge clk)
    begin
        rx_tick <= rx_tick + 1;
        if (rx_phase == 0)
        begin
            rx_mode  <= $urandom_range(0, 3);
            rx_phase <= $urandom_range(16, 80);
        end
        else
            rx_phase <= rx_phase - 1;
        case (rx_mode)
            0: pop <= 1'b1;
            1: pop <= ($urandom_range(0, 3) != 0);
            2: pop <= (rx_tick % 4 == 0);
            default:
            begin
                if (rx_stall != 0)
                begin
                    pop      <= 1'b0;
                    rx_stall <= rx_stall - 1;
                end
                else
                begin
                    pop <= 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        rx_stall <= $urandom_range(4, 12);
                end
            end
        endcase
    end

    task idle_gap(int cycles);
        @(negedge clk);
        push  <= 1'b0;
        op    <= 3'($urandom);
        value <= $urandom;
        nbits <= 6'($urandom);
        repeat (cycles - 1) @(negedge clk);
    endtask

    task send_request(logic [2:0] code, logic [31:0] data, logic [5:0] width);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 2) != 0)
                idle_gap($urandom_range(1, 6));
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge clk);
        push  <= 1'b1;
        op    <= code;
        value <= data;
        nbits <= width;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task send_random_request();
        int          pick;
        logic [5:0]  width;
        logic [2:0]  code;
        pick  = $urandom_range(0, 99);
        width = 6'($urandom);
        if (pick < 55)
        begin
            code = OP_BITS;
            pick = $urandom_range(0, 99);
            if (pick < 80)
                width = 6'($urandom_range(1, 32));
            else if (pick < 88)
                width = 6'd0;
            else
                width = 6'($urandom_range(33, 63));
        end
        else if (pick < 65)
            code = OP_U8;
        else if (pick < 72)
            code = OP_U16;
        else if (pick < 80)
            code = OP_U32;
        else if (pick < 93)
            code = OP_FLUSH;
        else
        begin
            case ($urandom_range(0, 2))
                0: code = OP_RSVD_A;
                1: code = OP_RSVD_B;
                default: code = OP_RSVD_C;
            endcase
        end
        send_request(code, $urandom, width);
    endtask

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_request(OP_FLUSH, 32'hFFFF_FFFF, 6'd63);
        send_request(OP_BITS, 32'hFFFF_FFFF, 6'd0);
        send_request(OP_BITS, 32'h0000_0001, 6'd1);
        send_request(OP_BITS, 32'h0000_007F, 6'd7);
        send_request(OP_BITS, 32'h0000_0005, 6'd3);
        send_request(OP_FLUSH, 32'h0, 6'd0);
        send_request(OP_BITS, 32'hFFFF_FFFF, 6'd32);
        send_request(OP_BITS, 32'h0000_0000, 6'd32);
        send_request(OP_BITS, 32'h0000_001F, 6'd5);
        send_request(OP_U8, 32'hFFFF_FFA5, 6'd0);
        send_request(OP_U8, 32'h0000_0000, 6'd63);
        send_request(OP_BITS, 32'h0000_0001, 6'd1);
        send_request(OP_U16, 32'h0000_FFFF, 6'd0);
        send_request(OP_U16, 32'hABCD_1234, 6'd0);
        send_request(OP_BITS, 32'hFFFF_FFFF, 6'd63);
        send_request(OP_BITS, 32'h8000_0001, 6'd33);
        send_request(OP_BITS, 32'h0000_000A, 6'd4);
        send_request(OP_U32, 32'hDEAD_BEEF, 6'd0);
        send_request(OP_U32, 32'hFFFF_FFFF, 6'd63);
        send_request(OP_RSVD_A, 32'hFFFF_FFFF, 6'd8);
        send_request(OP_RSVD_B, 32'h5555_5555, 6'd32);
        send_request(OP_RSVD_C, 32'hAAAA_AAAA, 6'd63);
        send_request(OP_BITS, 32'h0000_0000, 6'd7);
        send_request(OP_BITS, 32'h0000_0001, 6'd1);
        send_request(OP_FLUSH, 32'h0, 6'd0);

        repeat (RANDOM_REQUESTS)
            send_random_request();

        @(negedge clk);
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected bytes never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
